@@ hw/rtl/hcbd_pkg.sv @@
// Shared types, constants and helpers for the HTTP chunked body decoder.
package hcbd_pkg;

  localparam int MAX_CAPACITY  = 2049;
  localparam int FRAMING_LIMIT = 2048;
  localparam int LINE_BUFFER   = 24;

  localparam int CNT_W = 12;
  localparam int LL_W  = 5;

  localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_CAPACITY);
  localparam logic [CNT_W:0]   FRAME_MAX = (CNT_W+1)'(FRAMING_LIMIT);
  localparam logic [LL_W-1:0]  LINE_MAX = LL_W'(LINE_BUFFER - 1);

  // Request codes.
  localparam logic [1:0] REQ_STREAM = 2'd0;
  localparam logic [1:0] REQ_ABORT  = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Characters the framing cares about.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SPC = 8'h20;

  typedef enum logic [8:0] {
    PH_SIZE     = 9'b000000001,
    PH_SIZE_LF  = 9'b000000010,
    PH_DATA     = 9'b000000100,
    PH_DATA_CR  = 9'b000001000,
    PH_DATA_LF  = 9'b000010000,
    PH_TRAIL    = 9'b000100000,
    PH_TRAIL_LF = 9'b001000000,
    PH_DONE     = 9'b010000000,
    PH_FAIL     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_byte;
    logic [1:0]       status;
    logic [CNT_W-1:0] body_length;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ hw/rtl/hcbd_apb_regs.sv @@
// APB register file holding the body capacity setting.
module hcbd_apb_regs import hcbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] body_capacity
);

  logic sel_cap;

  // Word index is paddr[2]; only word 0 exists.
  assign sel_cap = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = sel_cap ? {{(32-CNT_W){1'b0}}, body_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_capacity <= CAP_MAX;
    end else if (psel && penable && pwrite && pready && sel_cap) begin
      body_capacity <= pwdata[CNT_W-1:0];
    end
  end

endmodule

@@ hw/rtl/hcbd_core.sv @@
// Per-word decode state and next-state logic for chunked framing.
module hcbd_core import hcbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       req_type,
  input  logic [7:0]       data_byte,
  input  logic [CNT_W-1:0] body_capacity,
  output res_t             res
);

  phase_t           phase, phase_next;
  logic [LL_W-1:0]  line_length, line_length_next;
  logic             line_bad, line_bad_next;
  logic [CNT_W-1:0] chunk_size, chunk_size_next;
  logic [CNT_W-1:0] chunk_left, chunk_left_next;
  logic [CNT_W-1:0] bytes_written, bytes_written_next;
  logic [CNT_W-1:0] framing_count, framing_count_next;

  logic             busy;
  logic             cap_ok;
  logic             is_size;
  logic [CNT_W:0]   fc_inc;
  logic [LL_W-1:0]  ll_inc;
  logic [CNT_W:0]   used;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] room_minus_v;
  logic [CNT_W-1:0] left_dec;
  logic             digit_ok;
  hex_t             hex;

  assign busy    = (phase != PH_DONE) && (phase != PH_FAIL);
  assign cap_ok  = (body_capacity >= CAP_MIN) && (body_capacity <= CAP_MAX);
  assign is_size = (phase == PH_SIZE);
  assign fc_inc  = {1'b0, framing_count} + (CNT_W+1)'(1);
  assign ll_inc  = line_length + LL_W'(1);
  assign used    = {1'b0, bytes_written} + (CNT_W+1)'(1);
  assign room    = ({1'b0, body_capacity} < used) ? '0
                                                  : CNT_W'({1'b0, body_capacity} - used);
  assign hex          = hex_decode(data_byte);
  assign room_minus_v = room - CNT_W'(hex.value);
  // The accumulated size may grow by one more digit only if it still fits the room.
  assign digit_ok = hex.ok && (CNT_W'(hex.value) <= room) &&
                    (chunk_size <= (room_minus_v >> 4));
  assign left_dec = (chunk_left != '0) ? chunk_left - CNT_W'(1) : chunk_left;

  always_comb begin
    phase_next         = phase;
    line_length_next   = line_length;
    line_bad_next      = line_bad;
    chunk_size_next    = chunk_size;
    chunk_left_next    = chunk_left;
    bytes_written_next = bytes_written;
    framing_count_next = framing_count;
    res.out_valid      = 1'b0;
    res.out_byte       = 8'd0;

    if (accept) begin
      unique case (req_type)
        REQ_START: begin
          phase_next         = PH_SIZE;
          line_length_next   = '0;
          line_bad_next      = 1'b0;
          chunk_size_next    = '0;
          chunk_left_next    = '0;
          bytes_written_next = '0;
          framing_count_next = '0;
        end
        REQ_ABORT: begin
          if (busy) begin
            phase_next = PH_FAIL;
          end
        end
        REQ_STREAM: begin
          if (busy && !cap_ok) begin
            phase_next = PH_FAIL;
          end else if (busy) begin
            unique case (phase)
              PH_SIZE, PH_TRAIL: begin
                framing_count_next = fc_inc[CNT_W-1:0];
                if (fc_inc > FRAME_MAX || data_byte == CH_NUL || data_byte == CH_LF) begin
                  phase_next = PH_FAIL;
                end else if (data_byte == CH_CR) begin
                  phase_next = is_size ? PH_SIZE_LF : PH_TRAIL_LF;
                end else if (data_byte < CH_SPC && data_byte != CH_TAB) begin
                  phase_next = PH_FAIL;
                end else begin
                  line_length_next = ll_inc;
                  if (ll_inc >= LINE_MAX) begin
                    phase_next = PH_FAIL;
                  end else if (!is_size) begin
                    line_bad_next = 1'b1;
                  end else if (!line_bad) begin
                    if (!digit_ok) begin
                      line_bad_next = 1'b1;
                    end else begin
                      chunk_size_next = {chunk_size[CNT_W-5:0], hex.value};
                    end
                  end
                end
              end
              PH_SIZE_LF: begin
                framing_count_next = fc_inc[CNT_W-1:0];
                if (fc_inc > FRAME_MAX || data_byte != CH_LF ||
                    line_length == '0 || line_bad) begin
                  phase_next = PH_FAIL;
                end else if (chunk_size == '0) begin
                  phase_next       = PH_TRAIL;
                  line_length_next = '0;
                  line_bad_next    = 1'b0;
                end else if (chunk_size > room) begin
                  phase_next = PH_FAIL;
                end else begin
                  chunk_left_next = chunk_size;
                  phase_next      = PH_DATA;
                end
              end
              PH_DATA: begin
                res.out_valid      = 1'b1;
                res.out_byte       = data_byte;
                bytes_written_next = bytes_written + CNT_W'(1);
                chunk_left_next    = left_dec;
                if (left_dec == '0) begin
                  phase_next = PH_DATA_CR;
                end
              end
              PH_DATA_CR: begin
                line_bad_next = (data_byte != CH_CR);
                phase_next    = PH_DATA_LF;
              end
              PH_DATA_LF: begin
                if (line_bad || data_byte != CH_LF) begin
                  phase_next = PH_FAIL;
                end else begin
                  phase_next       = PH_SIZE;
                  line_length_next = '0;
                  line_bad_next    = 1'b0;
                  chunk_size_next  = '0;
                end
              end
              PH_TRAIL_LF: begin
                framing_count_next = fc_inc[CNT_W-1:0];
                if (fc_inc > FRAME_MAX || data_byte != CH_LF ||
                    line_bad || bytes_written == '0) begin
                  phase_next = PH_FAIL;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              default: begin
                phase_next = PH_FAIL;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    res.status      = (phase_next == PH_DONE) ? ST_DONE :
                      (phase_next == PH_FAIL) ? ST_FAIL : ST_BUSY;
    res.body_length = bytes_written_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      line_length   <= '0;
      line_bad      <= 1'b0;
      chunk_size    <= '0;
      chunk_left    <= '0;
      bytes_written <= '0;
      framing_count <= '0;
    end else begin
      phase         <= phase_next;
      line_length   <= line_length_next;
      line_bad      <= line_bad_next;
      chunk_size    <= chunk_size_next;
      chunk_left    <= chunk_left_next;
      bytes_written <= bytes_written_next;
      framing_count <= framing_count_next;
    end
  end

endmodule

@@ hw/rtl/hcbd_out_reg.sv @@
// Result register between the decode logic and the output channel.
module hcbd_out_reg import hcbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  input  logic res_ready,
  output logic res_valid,
  output logic can_load,
  output res_t res_q
);

  assign can_load = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

@@ hw/rtl/http_chunked_body_decoder_top.sv @@
// Top level of the HTTP chunked body decoder.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_ready    req_type, data_byte
//   result   out        res_valid / res_ready  out_valid, out_byte, status, body_length
//   config   in         APB psel/penable       paddr, pwdata, prdata (body_capacity)
//
// Every accepted word produces exactly one result word in the next cycle.
// The decoder takes one word per cycle when in_ready is high; its state update
// is a single pass of shallow logic from input pins into state and result registers.
// in_ready is low only while a result is held and res_ready is low.
// Reset is synchronous and active high; it restores body_capacity to 2049 and
// returns the decoder to the start of a size line.
module http_chunked_body_decoder_top import hcbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // Input word channel.
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       req_type,
  input  logic [7:0]       data_byte,
  // Result word channel.
  output logic             res_valid,
  input  logic             res_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] body_length,
  // Configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic             accept;
  logic [CNT_W-1:0] body_capacity;
  res_t             res_next;
  res_t             res_q;

  // A word is taken whenever the result register is free or being drained.
  assign accept = in_valid && in_ready;

  hcbd_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .body_capacity (body_capacity)
  );

  // Framing state machine; produces the result for the accepted word.
  hcbd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .body_capacity (body_capacity),
    .res           (res_next)
  );

  // The result register decouples the output handshake from the decoder.
  hcbd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_next),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .can_load  (in_ready),
    .res_q     (res_q)
  );

  assign out_valid   = res_q.out_valid;
  assign out_byte    = res_q.out_byte;
  assign status      = res_q.status;
  assign body_length = res_q.body_length;

endmodule

@@ hw/rtl/hcbd_checker.sv @@
// Port-level checks for the chunked body decoder, bound to the top level.
module hcbd_checker import hcbd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       req_type,
  input logic             res_valid,
  input logic             res_ready,
  input logic             out_valid,
  input logic [7:0]       out_byte,
  input logic [1:0]       status,
  input logic [CNT_W-1:0] body_length
);

  // A payload byte can only appear while decoding is still in progress.
  a_payload_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> status == ST_BUSY)
    else $error("payload byte reported with final status");

  // A word without payload carries a zero byte.
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_valid |-> out_byte == 8'd0)
    else $error("non-payload result carries a byte");

  // Starting a new body yields an empty, in-progress result next cycle.
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_START |=>
      res_valid && body_length == '0 && status == ST_BUSY && !out_valid)
    else $error("start request did not clear the body");

  // Body length never exceeds the largest capacity less one.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> body_length <= CAP_MAX - CNT_W'(1))
    else $error("body length out of range");

  // A stalled result holds its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(body_length) && $stable(status))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (.*);
